@@ rtl/bcs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bcs_pkg;

  localparam int unsigned IndexWidth = 6;
  localparam int unsigned CountWidth = 7;
  localparam int unsigned TFrac      = 16;
  localparam int unsigned TWidth     = TFrac + 1;
  localparam int unsigned TOne       = 1 << TFrac;
  localparam int unsigned NumPoints  = 4;
  localparam int unsigned NumAxes    = 3;
  localparam int unsigned LaneDepth  = 3;

  localparam logic [CountWidth-1:0] SampleCountReset = CountWidth'(10);

  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic [IndexWidth-1:0] idx;
  } bcs_tag_t;

endpackage

`default_nettype wire

@@ rtl/bcs_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bcs_pts_if #(
  parameter int unsigned CoordWidth = 16
);
  logic                  valid;
  logic                  ready;
  logic [CoordWidth-1:0] p0_x;
  logic [CoordWidth-1:0] p0_y;
  logic [CoordWidth-1:0] p0_z;
  logic [CoordWidth-1:0] p1_x;
  logic [CoordWidth-1:0] p1_y;
  logic [CoordWidth-1:0] p1_z;
  logic [CoordWidth-1:0] p2_x;
  logic [CoordWidth-1:0] p2_y;
  logic [CoordWidth-1:0] p2_z;
  logic [CoordWidth-1:0] p3_x;
  logic [CoordWidth-1:0] p3_y;
  logic [CoordWidth-1:0] p3_z;

  modport source (
    output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
    output p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
    input  ready
  );
  modport sink (
    input  valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
    input  p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
    output ready
  );
endinterface

interface bcs_curve_if #(
  parameter int unsigned CoordWidth = 16
);
  logic                  valid;
  logic                  ready;
  logic [CoordWidth-1:0] curve_x;
  logic [CoordWidth-1:0] curve_y;
  logic [CoordWidth-1:0] curve_z;
  logic [5:0]            sample_index;
  logic                  last_sample;

  modport source (
    output valid, curve_x, curve_y, curve_z, sample_index, last_sample,
    input  ready
  );
  modport sink (
    input  valid, curve_x, curve_y, curve_z, sample_index, last_sample,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/bcs_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bcs_seq #(
  parameter int unsigned MaxSamples = 64,
  parameter int unsigned CoordWidth = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bcs_pkg::CountWidth-1:0]     cfg_wdata_i,
  bcs_pts_if.sink                            pts_i,
  input  logic                               adv_i,
  output bcs_pkg::bcs_tag_t                  tag_o,
  output logic [bcs_pkg::NumPoints-1:0][bcs_pkg::NumAxes-1:0][CoordWidth-1:0] p_o,
  output logic [bcs_pkg::TWidth-1:0]         t_o
);
  import bcs_pkg::*;

  localparam int unsigned DistWidth = $clog2(MaxSamples);
  localparam int unsigned TabDepth  = 1 << DistWidth;

  typedef logic [NumPoints-1:0][NumAxes-1:0][CoordWidth-1:0] pts_t;

  logic [TWidth-1:0]    step_q_tab [TabDepth];
  logic [DistWidth-1:0] step_r_tab [TabDepth];

  for (genvar g = 0; g < TabDepth; g++) begin : g_step
    localparam int unsigned Div = (g == 0) ? 1 : g;
    assign step_q_tab[g] = TWidth'(TOne / Div);
    assign step_r_tab[g] = DistWidth'(TOne % Div);
  end

  logic [CountWidth-1:0] count_q;
  logic                  busy_q;
  logic [DistWidth-1:0]  n_q;
  logic [DistWidth-1:0]  d_q;
  logic [TWidth-1:0]     sq_q;
  logic [DistWidth-1:0]  sr_q;
  logic [TWidth-1:0]     acc_t_q;
  logic [DistWidth-1:0]  acc_r_q;
  pts_t                  pts_q;
  bcs_tag_t              tag_q;
  bcs_tag_t              tag_d;
  pts_t                  p_q;
  logic [TWidth-1:0]     t_q;

  pts_t                  pts_in;
  logic [DistWidth-1:0]  d_cfg;
  logic                  accept;
  logic                  last_issue;
  logic [DistWidth:0]    r_sum;
  logic                  wrap;
  logic [DistWidth-1:0]  acc_r_d;
  logic [TWidth-1:0]     acc_t_d;

  always_comb begin
    if (count_q < CountWidth'(2)) begin
      d_cfg = DistWidth'(1);
    end else if (32'(count_q) > MaxSamples) begin
      d_cfg = DistWidth'(MaxSamples - 1);
    end else begin
      d_cfg = DistWidth'(count_q - CountWidth'(1));
    end
  end

  assign pts_in[0] = {pts_i.p0_z, pts_i.p0_y, pts_i.p0_x};
  assign pts_in[1] = {pts_i.p1_z, pts_i.p1_y, pts_i.p1_x};
  assign pts_in[2] = {pts_i.p2_z, pts_i.p2_y, pts_i.p2_x};
  assign pts_in[3] = {pts_i.p3_z, pts_i.p3_y, pts_i.p3_x};

  assign last_issue  = busy_q && (n_q == d_q);
  assign pts_i.ready = !busy_q || (adv_i && last_issue);
  assign accept      = pts_i.valid && pts_i.ready;

  // advance t by 1/(count-1): whole step plus carried remainder
  assign r_sum   = {1'b0, acc_r_q} + {1'b0, sr_q};
  assign wrap    = r_sum >= {1'b0, d_q};
  assign acc_r_d = wrap ? DistWidth'(r_sum - {1'b0, d_q}) : DistWidth'(r_sum);
  assign acc_t_d = acc_t_q + sq_q + TWidth'(wrap);

  always_comb begin
    tag_d.valid = busy_q;
    tag_d.last  = n_q == d_q;
    tag_d.idx   = IndexWidth'(n_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= SampleCountReset;
      busy_q  <= 1'b0;
      tag_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (accept) begin
        busy_q <= 1'b1;
      end else if (adv_i && last_issue) begin
        busy_q <= 1'b0;
      end
      if (adv_i) begin
        tag_q <= tag_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pts_q   <= pts_in;
      d_q     <= d_cfg;
      sq_q    <= step_q_tab[d_cfg];
      sr_q    <= step_r_tab[d_cfg];
      n_q     <= '0;
      acc_t_q <= '0;
      acc_r_q <= '0;
    end else if (adv_i && busy_q) begin
      n_q     <= n_q + DistWidth'(1);
      acc_t_q <= acc_t_d;
      acc_r_q <= acc_r_d;
    end
    if (adv_i) begin
      p_q <= pts_q;
      t_q <= acc_t_q;
    end
  end

  assign tag_o = tag_q;
  assign p_o   = p_q;
  assign t_o   = t_q;

  a_first_t_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && adv_i && (n_q == '0) |=> t_q == '0)
    else $error("first sample of a request not at t = 0");

  a_last_t_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && last_issue |=> t_q == TWidth'(TOne))
    else $error("last sample of a request not at t = 1");

  a_accept_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && busy_q |-> adv_i && last_issue)
    else $error("request taken while samples still pending");

  a_remainder_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> acc_r_q < d_q)
    else $error("step remainder out of range");

endmodule

`default_nettype wire

@@ rtl/bcs_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bcs_lane #(
  parameter int unsigned CoordWidth = 16
) (
  input  logic                                         clk_i,
  input  logic                                         adv_i,
  input  logic [bcs_pkg::NumPoints-1:0][CoordWidth-1:0] p_i,
  input  logic [bcs_pkg::TWidth-1:0]                   t_i,
  output logic [CoordWidth-1:0]                        c_o
);
  import bcs_pkg::*;

  localparam int unsigned ProdWidth = CoordWidth + TWidth + 2;

  function automatic logic [CoordWidth-1:0] lerp(
    input logic [CoordWidth-1:0] p,
    input logic [CoordWidth-1:0] q,
    input logic [TWidth-1:0]     t
  );
    logic signed [CoordWidth:0]  diff;
    logic signed [ProdWidth-1:0] prod;
    logic signed [ProdWidth-1:0] sh;
    diff = $signed({q[CoordWidth-1], q}) - $signed({p[CoordWidth-1], p});
    prod = diff * $signed({1'b0, t});
    sh   = prod >>> TFrac;
    return p + sh[CoordWidth-1:0];
  endfunction

  logic [2:0][CoordWidth-1:0] l1_q;
  logic [TWidth-1:0]          t1_q;
  logic [1:0][CoordWidth-1:0] l2_q;
  logic [TWidth-1:0]          t2_q;
  logic [CoordWidth-1:0]      c_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      l1_q[0] <= lerp(p_i[0], p_i[1], t_i);
      l1_q[1] <= lerp(p_i[1], p_i[2], t_i);
      l1_q[2] <= lerp(p_i[2], p_i[3], t_i);
      t1_q    <= t_i;
      l2_q[0] <= lerp(l1_q[0], l1_q[1], t1_q);
      l2_q[1] <= lerp(l1_q[1], l1_q[2], t1_q);
      t2_q    <= t1_q;
      c_q     <= lerp(l2_q[0], l2_q[1], t2_q);
    end
  end

  assign c_o = c_q;

endmodule

`default_nettype wire

@@ rtl/bcs_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bcs_merge #(
  parameter int unsigned CoordWidth = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  bcs_pkg::bcs_tag_t                          tag_i,
  input  logic [bcs_pkg::NumAxes-1:0][CoordWidth-1:0] c_i,
  output logic                                       adv_o,
  bcs_curve_if.source                                curve_o
);
  import bcs_pkg::*;

  bcs_tag_t              dl_q [LaneDepth];
  logic                  ov_q;
  logic [CoordWidth-1:0] x_q;
  logic [CoordWidth-1:0] y_q;
  logic [CoordWidth-1:0] z_q;
  logic [IndexWidth-1:0] idx_q;
  logic                  last_q;

  assign adv_o = !ov_q || curve_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LaneDepth; k++) begin
        dl_q[k] <= '0;
      end
      ov_q <= 1'b0;
    end else if (adv_o) begin
      dl_q[0] <= tag_i;
      for (int k = 1; k < LaneDepth; k++) begin
        dl_q[k] <= dl_q[k-1];
      end
      ov_q <= dl_q[LaneDepth-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      x_q    <= c_i[0];
      y_q    <= c_i[1];
      z_q    <= c_i[2];
      idx_q  <= dl_q[LaneDepth-1].idx;
      last_q <= dl_q[LaneDepth-1].last;
    end
  end

  assign curve_o.valid        = ov_q;
  assign curve_o.curve_x      = x_q;
  assign curve_o.curve_y      = y_q;
  assign curve_o.curve_z      = z_q;
  assign curve_o.sample_index = idx_q;
  assign curve_o.last_sample  = last_q;

endmodule

`default_nettype wire

@@ rtl/cubic_bezier_curve_sampler.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake      Payload
// pts_i     in   valid/ready    p0..p3 x/y/z, signed Q4.12
// curve_o   out  valid/ready    curve_x/y/z, sample_index, last_sample
// cfg       in   cfg_we_i       cfg_wdata_i = sample_count
//
// Each request yields sample_count results (clamped to 2..MAX_SAMPLES), one per cycle
// while not stalled; a request holds the issue sequencer until its last sample issues.
// A new request is taken in the cycle its predecessor's last sample issues.
// A first result passes the issue stage, three lerp levels and the output register.
// A result not taken freezes the whole pipeline; reset clears count to 10 and all valids.
module cubic_bezier_curve_sampler #(
  parameter int unsigned MAX_SAMPLES = 64,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bcs_pkg::CountWidth-1:0] cfg_wdata_i,
  bcs_pts_if.sink                        pts_i,
  bcs_curve_if.source                    curve_o
);
  import bcs_pkg::*;

  logic                                                 adv;
  bcs_tag_t                                             iss_tag;
  logic [NumPoints-1:0][NumAxes-1:0][COORD_WIDTH-1:0]   iss_p;
  logic [TWidth-1:0]                                    iss_t;
  logic [NumAxes-1:0][NumPoints-1:0][COORD_WIDTH-1:0]   lane_p;
  logic [NumAxes-1:0][COORD_WIDTH-1:0]                  lane_c;

  bcs_seq #(
    .MaxSamples (MAX_SAMPLES),
    .CoordWidth (COORD_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pts_i       (pts_i),
    .adv_i       (adv),
    .tag_o       (iss_tag),
    .p_o         (iss_p),
    .t_o         (iss_t)
  );

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      for (int k = 0; k < NumPoints; k++) begin
        lane_p[a][k] = iss_p[k][a];
      end
    end
  end

  for (genvar a = 0; a < NumAxes; a++) begin : g_lane
    bcs_lane #(
      .CoordWidth (COORD_WIDTH)
    ) u_lane (
      .clk_i (clk_i),
      .adv_i (adv),
      .p_i   (lane_p[a]),
      .t_i   (iss_t),
      .c_o   (lane_c[a])
    );
  end

  bcs_merge #(
    .CoordWidth (COORD_WIDTH)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (iss_tag),
    .c_i     (lane_c),
    .adv_o   (adv),
    .curve_o (curve_o)
  );

endmodule

`default_nettype wire
